// ----- rtl/core/sgm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel gradient magnitude package
// Shared constants, types and helpers of the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

   localparam int MAX_COLS_DEF = 2048;
   localparam int PIX_W        = 8;
   localparam int ROW_W        = 12;
   localparam int OCOL_W       = 11;
   localparam int GRAD_W       = 15;
   localparam int MAG_W        = 15;
   localparam int RSP_DATA_W   = 72;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;

   localparam logic [12:0] ROWS_RESET = 13'd720;
   localparam logic [11:0] COLS_RESET = 12'd1080;
   localparam logic [3:0]  EDGE_RESET = 4'd3;
   localparam logic [4:0]  MID_RESET  = 5'd10;

   typedef enum logic [1:0] {
      CSR_IMAGE_ROWS = 2'd0,
      CSR_IMAGE_COLS = 2'd1,
      CSR_COEF_EDGE  = 2'd2,
      CSR_COEF_MID   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [12:0] image_rows;
      logic [11:0] image_cols;
      logic [3:0]  coef_edge;
      logic [4:0]  coef_mid;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]                 row;
      logic [OCOL_W-1:0]                col;
      logic                             done;
      logic [2:0][2:0][PIX_W-1:0]       pix;
   } job_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_LOAD,
      F_EMIT
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SUM,
      B_SQ_ROWS,
      B_SQ_COLS,
      B_ROOT,
      B_OUT
   } back_state_type;

   // Window tap for kernel position idx; on the last column or row the
   // outer tap repeats the border pixel.
   function automatic logic [1:0] tap_sel(input logic [1:0] idx, input logic last);
      logic [1:0] r;
      case (idx)
         2'd0: r = last ? 2'd1 : 2'd0;
         2'd1: r = last ? 2'd2 : 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/sobel_gradient_magnitude.sv -----
// ----------------------------------------------------------------------------
// Sobel gradient magnitude
// 3x3 Sobel edge magnitude over a raster pixel stream with clamped borders.
//
//   channel  direction  payload
//   req_     in         tdata[7:0] pixel
//   rsp_     out        tdata out_row, out_col, grad_rows, grad_cols,
//                       magnitude; tlast image_done
//   csr_     in         write enable, register index, write data
//
// The front end takes a new pixel once it has queued each result of the last;
// the back end starts a new job once its result is in the output register,
// and its one-bit-a-step square root sets the sustained rate.
// Reset is synchronous and clears control state; line stores are not cleared.
// The four-entry job queue and the output register let either side stall.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
   parameter int MaxCols = sgm_pkg::MAX_COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] out_row, [22:12] out_col, [37:23] grad_rows, [52:38] grad_cols,
   // [67:53] magnitude, [71:68] zero
   output logic [sgm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [sgm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   sgm_pkg::cfg_type          cfg_ff;
   sgm_pkg::job_type          front_job, queue_job;
   sgm_pkg::queue_status_type qstat;
   logic                      job_push, job_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_rows <= sgm_pkg::ROWS_RESET;
         cfg_ff.image_cols <= sgm_pkg::COLS_RESET;
         cfg_ff.coef_edge  <= sgm_pkg::EDGE_RESET;
         cfg_ff.coef_mid   <= sgm_pkg::MID_RESET;
      end else if (csr_we) begin
         case (sgm_pkg::csr_index_type'(csr_index))
            sgm_pkg::CSR_IMAGE_ROWS: cfg_ff.image_rows <= csr_wdata[12:0];
            sgm_pkg::CSR_IMAGE_COLS: cfg_ff.image_cols <= csr_wdata[11:0];
            sgm_pkg::CSR_COEF_EDGE:  cfg_ff.coef_edge  <= csr_wdata[3:0];
            sgm_pkg::CSR_COEF_MID:   cfg_ff.coef_mid   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   sgm_front #(.MaxCols(MaxCols)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .job        (front_job),
      .job_push   (job_push),
      .qstat      (qstat)
   );

   sgm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (front_job),
      .pop     (job_pop),
      .job_out (queue_job),
      .qstat   (qstat)
   );

   sgm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job         (queue_job),
      .queue_empty (qstat.empty),
      .pop         (job_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   logic signed [14:0] out_gr, out_gc;
   logic [31:0]        grad_sq, mag_sq, mag_up_sq;

   always_comb begin
      out_gr    = signed'(rsp_tdata[37:23]);
      out_gc    = signed'(rsp_tdata[52:38]);
      grad_sq   = 32'(out_gr * out_gr) + 32'(out_gc * out_gc);
      mag_sq    = 32'(rsp_tdata[67:53]) * 32'(rsp_tdata[67:53]);
      mag_up_sq = (32'(rsp_tdata[67:53]) + 32'd1) * (32'(rsp_tdata[67:53]) + 32'd1);
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= sgm_pkg::QCNT_W'(sgm_pkg::QUEUE_DEPTH))
      else $error("job queue count beyond its depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !qstat.full)
      else $error("job pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> $past(!qstat.empty))
      else $error("job popped from an empty queue");

   a_mag_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mag_sq <= grad_sq) && (mag_up_sq > grad_sq))
      else $error("magnitude is not the floor of the root");

endmodule

// ----- rtl/core/sgm_front.sv -----
// ----------------------------------------------------------------------------
// Sobel front end
// Takes pixels, keeps the line stores and the 3x3 window, and queues one job
// per result that each pixel causes.
// ----------------------------------------------------------------------------
module sgm_front #(
   parameter int MaxCols = sgm_pkg::MAX_COLS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sgm_pkg::cfg_type          cfg,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   output sgm_pkg::job_type          job,
   output logic                      job_push,
   input  sgm_pkg::queue_status_type qstat
);

   localparam int ColW = $clog2(MaxCols);

   sgm_pkg::front_state_type state_ff, state_in;

   logic [7:0]        pix_ff;
   logic [11:0]       row_ff, cur_row_ff;
   logic [ColW-1:0]   col_ff, cur_col_ff;
   logic [3:0]        pend_ff;
   logic [2:0][2:0][7:0] win_ff;
   logic [7:0]        older_mem [MaxCols];
   logic [7:0]        newer_mem [MaxCols];
   logic [7:0]        older_rd_ff, newer_rd_ff;

   logic [12:0]       rows_eff;
   logic [ColW:0]     cols_eff;
   logic              restart, accept, load;
   logic [11:0]       start_row;
   logic [ColW-1:0]   start_col;
   logic [7:0]        mid, top;
   logic              last_col, last_row;
   logic [3:0]        flags;
   logic [ColW:0]     col_nxt;
   logic [12:0]       row_nxt;
   logic [1:0]        kind;

   function automatic logic [sgm_pkg::OCOL_W-1:0] OCOL_W_TRUNC(input logic [ColW-1:0] c,
                                                             input logic step);
      logic [ColW+sgm_pkg::OCOL_W:0] w;
      w = (ColW+sgm_pkg::OCOL_W+1)'(c) - (ColW+sgm_pkg::OCOL_W+1)'(1)
          + (ColW+sgm_pkg::OCOL_W+1)'(step);
      return w[sgm_pkg::OCOL_W-1:0];
   endfunction

   always_comb begin
      if (cfg.image_rows < 13'd2) begin
         rows_eff = 13'd2;
      end else if (cfg.image_rows > 13'd4096) begin
         rows_eff = 13'd4096;
      end else begin
         rows_eff = cfg.image_rows;
      end
      if (32'(cfg.image_cols) < 32'd2) begin
         cols_eff = (ColW+1)'(2);
      end else if (32'(cfg.image_cols) > 32'(MaxCols)) begin
         cols_eff = (ColW+1)'(MaxCols);
      end else begin
         cols_eff = (ColW+1)'(cfg.image_cols);
      end
   end

   assign restart   = ({1'b0, row_ff} >= rows_eff) || ({1'b0, col_ff} >= cols_eff);
   assign start_row = restart ? '0 : row_ff;
   assign start_col = restart ? '0 : col_ff;

   assign mid      = (cur_row_ff == 12'd0) ? pix_ff : newer_rd_ff;
   assign top      = (cur_row_ff <= 12'd1) ? mid : older_rd_ff;
   assign last_col = ({1'b0, cur_col_ff} == cols_eff - 1'b1);
   assign last_row = ({1'b0, cur_row_ff} == rows_eff - 1'b1);
   assign col_nxt  = {1'b0, cur_col_ff} + 1'b1;
   assign row_nxt  = {1'b0, cur_row_ff} + 1'b1;

   always_comb begin
      flags = '0;
      if (cur_row_ff != 12'd0) begin
         flags[0] = (cur_col_ff != '0);
         flags[1] = last_col;
         flags[2] = last_row && (cur_col_ff != '0);
         flags[3] = last_row && last_col;
      end
   end

   always_comb begin
      kind = 2'd3;
      for (int k = 3; k >= 0; k--) begin
         if (pend_ff[k]) begin
            kind = 2'(k);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sgm_pkg::F_IDLE: begin
            if (req_tvalid) begin
               state_in = sgm_pkg::F_LOAD;
            end
         end
         sgm_pkg::F_LOAD: state_in = sgm_pkg::F_EMIT;
         sgm_pkg::F_EMIT: begin
            if (pend_ff == '0) begin
               state_in = sgm_pkg::F_IDLE;
            end
         end
         default: state_in = sgm_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == sgm_pkg::F_IDLE);
      accept     = req_tready && req_tvalid;
      load       = (state_ff == sgm_pkg::F_LOAD);
      job_push   = (state_ff == sgm_pkg::F_EMIT) && (pend_ff != '0) && !qstat.full;
   end

   always_comb begin
      job.row  = cur_row_ff - 12'd1 + {11'd0, kind[1]};
      job.col  = OCOL_W_TRUNC(cur_col_ff, kind[0]);
      job.done = (kind == 2'd3);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            job.pix[i][j] = win_ff[sgm_pkg::tap_sel(2'(j), kind[0])]
                                  [sgm_pkg::tap_sel(2'(i), kind[1])];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgm_pkg::F_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            pend_ff <= flags;
            if (col_nxt >= cols_eff) begin
               col_ff <= '0;
               row_ff <= (row_nxt >= rows_eff) ? 12'd0 : row_nxt[11:0];
            end else begin
               col_ff <= col_nxt[ColW-1:0];
               row_ff <= cur_row_ff;
            end
         end else if (job_push) begin
            pend_ff[kind] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff      <= req_tdata;
         cur_row_ff  <= start_row;
         cur_col_ff  <= start_col;
         older_rd_ff <= older_mem[start_col];
         newer_rd_ff <= newer_mem[start_col];
      end
      if (load) begin
         newer_mem[cur_col_ff] <= pix_ff;
         if (cur_row_ff != 12'd0) begin
            older_mem[cur_col_ff] <= newer_rd_ff;
         end
         if (cur_col_ff == '0) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k][0] <= top;
               win_ff[k][1] <= mid;
               win_ff[k][2] <= pix_ff;
            end
         end else begin
            win_ff[0]    <= win_ff[1];
            win_ff[1]    <= win_ff[2];
            win_ff[2][0] <= top;
            win_ff[2][1] <= mid;
            win_ff[2][2] <= pix_ff;
         end
      end
   end

endmodule

// ----- rtl/core/sgm_queue.sv -----
// ----------------------------------------------------------------------------
// Sobel job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module sgm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sgm_pkg::job_type          job_in,
   input  logic                      pop,
   output sgm_pkg::job_type          job_out,
   output sgm_pkg::queue_status_type qstat
);

   sgm_pkg::job_type                slot_ff [sgm_pkg::QUEUE_DEPTH];
   logic [sgm_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [sgm_pkg::QCNT_W-1:0]      count_ff, count_in;

   always_comb begin
      qstat.count = count_ff;
      qstat.full  = (count_ff == sgm_pkg::QCNT_W'(sgm_pkg::QUEUE_DEPTH));
      qstat.empty = (count_ff == '0);
      job_out     = slot_ff[rd_ptr_ff];
      count_in    = count_ff + sgm_pkg::QCNT_W'(push) - sgm_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ----- rtl/core/sgm_back.sv -----
// ----------------------------------------------------------------------------
// Sobel back end
// Computes both gradients, their squared sum and its integer square root,
// and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module sgm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sgm_pkg::cfg_type          cfg,
   input  sgm_pkg::job_type          job,
   input  logic                      queue_empty,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sgm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);

   sgm_pkg::back_state_type state_ff, state_in;

   sgm_pkg::job_type    job_ff;
   logic signed [16:0]  gr_ff, gc_ff;
   logic [30:0]         sq_ff, rem_ff, res_ff, bit_ff;
   logic [3:0]          step_ff;
   logic                rsp_tvalid_ff, rsp_tlast_ff;
   logic [sgm_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   logic                load_out;
   logic signed [10:0]  dr_edge, dc_edge;
   logic signed [8:0]   dr_mid, dc_mid;
   logic signed [4:0]   e_s;
   logic signed [5:0]   m_s;
   logic signed [16:0]  gr_in, gc_in, mult_op;
   logic signed [33:0]  prod;
   logic [30:0]         trial;

   assign e_s = signed'({1'b0, cfg.coef_edge});
   assign m_s = signed'({1'b0, cfg.coef_mid});

   always_comb begin
      dr_edge = 11'(job_ff.pix[0][0]) + 11'(job_ff.pix[0][2])
              - 11'(job_ff.pix[2][0]) - 11'(job_ff.pix[2][2]);
      dc_edge = 11'(job_ff.pix[0][0]) + 11'(job_ff.pix[2][0])
              - 11'(job_ff.pix[0][2]) - 11'(job_ff.pix[2][2]);
      dr_mid  = 9'(job_ff.pix[0][1]) - 9'(job_ff.pix[2][1]);
      dc_mid  = 9'(job_ff.pix[1][0]) - 9'(job_ff.pix[1][2]);
      gr_in   = 17'(e_s * dr_edge) + 17'(m_s * dr_mid);
      gc_in   = 17'(e_s * dc_edge) + 17'(m_s * dc_mid);
      mult_op = (state_ff == sgm_pkg::B_SQ_ROWS) ? gr_ff : gc_ff;
      prod    = mult_op * mult_op;
      trial   = res_ff + bit_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sgm_pkg::B_IDLE: begin
            if (!queue_empty) begin
               state_in = sgm_pkg::B_SUM;
            end
         end
         sgm_pkg::B_SUM:     state_in = sgm_pkg::B_SQ_ROWS;
         sgm_pkg::B_SQ_ROWS: state_in = sgm_pkg::B_SQ_COLS;
         sgm_pkg::B_SQ_COLS: state_in = sgm_pkg::B_ROOT;
         sgm_pkg::B_ROOT: begin
            if (step_ff == 4'd15) begin
               state_in = sgm_pkg::B_OUT;
            end
         end
         sgm_pkg::B_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = sgm_pkg::B_IDLE;
            end
         end
         default: state_in = sgm_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop        = (state_ff == sgm_pkg::B_IDLE) && !queue_empty;
      load_out   = (state_ff == sgm_pkg::B_OUT) && (!rsp_tvalid_ff || rsp_tready);
      rsp_tvalid = rsp_tvalid_ff;
      rsp_tdata  = rsp_tdata_ff;
      rsp_tlast  = rsp_tlast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sgm_pkg::B_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         sgm_pkg::B_IDLE: begin
            if (pop) begin
               job_ff <= job;
            end
         end
         sgm_pkg::B_SUM: begin
            gr_ff <= gr_in;
            gc_ff <= gc_in;
         end
         sgm_pkg::B_SQ_ROWS: sq_ff <= prod[30:0];
         sgm_pkg::B_SQ_COLS: begin
            rem_ff  <= sq_ff + prod[30:0];
            res_ff  <= '0;
            bit_ff  <= 31'h4000_0000;
            step_ff <= '0;
         end
         sgm_pkg::B_ROOT: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + 1'b1;
         end
         sgm_pkg::B_OUT: begin
            if (load_out) begin
               rsp_tdata_ff <= {4'd0, res_ff[14:0], gc_ff[14:0], gr_ff[14:0],
                                job_ff.col, job_ff.row};
               rsp_tlast_ff <= job_ff.done;
            end
         end
         default: ;
      endcase
   end

endmodule
